// ===== hw/rtl/sids_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sids_pkg: shared types and constants for the sorted identifier set
// Request and result words, operation codes and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package sids_pkg;

  localparam int CAPACITY    = 32;
  localparam int MAX_RESULTS = 32;
  localparam int ID_W        = 32;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int RUN_W       = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
  localparam int OP_W        = 3;
  localparam int FIELD_CNT_W = 6;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
  localparam logic [OP_W-1:0] OP_DUMP   = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] chunk_id;
  } in_word_t;

  typedef struct packed {
    logic                   was_present;
    logic                   dropped_full;
    logic [FIELD_CNT_W-1:0] entry_count;
    logic                   run_valid;
    logic [ID_W-1:0]        run_first;
    logic [ID_W-1:0]        run_final;
    logic                   last;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic apply;       // execute the request word at the input
    logic rotate;      // move every cell down by one, head wraps to the tail
    logic hold_first;  // capture head as the first value of the open run
    logic emit_run;    // load a run word into the output register
    logic use_head;    // run opened on this cycle: first value is the head
    logic run_last;    // run word closes the dump
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             head_consec;  // second cell is head + 1
    logic             out_free;     // output register can take a word
  } dp_stat_t;

  function automatic logic [FIELD_CNT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
    if ({1'b0, c} > (CNT_W + 1)'(63)) begin
      return 6'd63;
    end
    return FIELD_CNT_W'(c);
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sids_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sids_datapath: compare-and-shift cell array with output register
// Each cell compares its entry against the key in parallel; insert and
// delete shift the tail of the array by one place.
// ----------------------------------------------------------------------------
module sids_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  sids_pkg::dp_cmd_t        cmd,
  input  sids_pkg::in_word_t       in_word,
  input  wire logic                out_stall,
  output sids_pkg::dp_stat_t       stat,
  output logic                     out_valid,
  output sids_pkg::out_word_t      out_word
);

  localparam int CAP   = sids_pkg::CAPACITY;
  localparam int CW    = sids_pkg::CNT_W;
  localparam int HEAD1 = (CAP > 1) ? 1 : 0;

  logic [sids_pkg::ID_W-1:0] cell_r   [CAP];
  logic [sids_pkg::ID_W-1:0] cell_nxt [CAP];
  logic [CAP-1:0]            lt;
  logic [CAP-1:0]            eq;
  logic [CW-1:0]             count_r, count_nxt;
  logic [sids_pkg::ID_W-1:0] first_r;
  logic                      out_valid_r;
  sids_pkg::out_word_t       out_word_r;

  logic [sids_pkg::ID_W-1:0] key;
  logic [sids_pkg::ID_W-1:0] head;
  logic                      present, full;
  logic                      do_ins, do_del, do_clr;
  logic                      op_lookup;

  assign key  = in_word.chunk_id;
  assign head = cell_r[0];

  genvar gi;
  generate
    for (gi = 0; gi < CAP; gi++) begin : g_cell
      localparam int UP = (gi == CAP - 1) ? gi : gi + 1;
      localparam int DN = (gi == 0) ? 0 : gi - 1;
      localparam int RT = (gi == CAP - 1) ? 0 : gi + 1;
      logic held;

      assign held   = CW'(gi) < count_r;
      assign lt[gi] = held && (cell_r[gi] < key);
      assign eq[gi] = held && (cell_r[gi] == key);

      always_comb begin
        priority if (cmd.rotate) begin
          cell_nxt[gi] = cell_r[RT];
        end else if (do_ins) begin
          if (lt[gi]) begin
            cell_nxt[gi] = cell_r[gi];
          end else if ((gi == 0) || lt[DN]) begin
            cell_nxt[gi] = key;
          end else begin
            cell_nxt[gi] = cell_r[DN];
          end
        end else if (do_del && !lt[gi]) begin
          cell_nxt[gi] = cell_r[UP];
        end else begin
          cell_nxt[gi] = cell_r[gi];
        end
      end

      always_ff @(posedge clk) begin
        cell_r[gi] <= cell_nxt[gi];
      end
    end
  endgenerate

  assign present   = |eq;
  assign full      = count_r >= CW'(CAP);
  assign op_lookup = (in_word.op == sids_pkg::OP_INSERT) ||
                     (in_word.op == sids_pkg::OP_DELETE) ||
                     (in_word.op == sids_pkg::OP_QUERY);
  assign do_ins    = cmd.apply && (in_word.op == sids_pkg::OP_INSERT) && !present && !full;
  assign do_del    = cmd.apply && (in_word.op == sids_pkg::OP_DELETE) && present;
  assign do_clr    = cmd.apply && (in_word.op == sids_pkg::OP_CLEAR);

  always_comb begin
    priority if (do_clr) begin
      count_nxt = '0;
    end else if (do_ins) begin
      count_nxt = count_r + 1'b1;
    end else if (do_del) begin
      count_nxt = count_r - 1'b1;
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.apply || cmd.emit_run) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hold_first) begin
      first_r <= head;
    end
    if (cmd.apply) begin
      out_word_r.was_present  <= op_lookup && present;
      out_word_r.dropped_full <= (in_word.op == sids_pkg::OP_INSERT) && !present && full;
      out_word_r.entry_count  <= sids_pkg::sat_count(count_nxt);
      out_word_r.run_valid    <= 1'b0;
      out_word_r.run_first    <= '0;
      out_word_r.run_final    <= '0;
      out_word_r.last         <= 1'b1;
    end else if (cmd.emit_run) begin
      out_word_r.was_present  <= 1'b0;
      out_word_r.dropped_full <= 1'b0;
      out_word_r.entry_count  <= sids_pkg::sat_count(count_r);
      out_word_r.run_valid    <= 1'b1;
      out_word_r.run_first    <= cmd.use_head ? head : first_r;
      out_word_r.run_final    <= head;
      out_word_r.last         <= cmd.run_last;
    end
  end

  assign stat.count       = count_r;
  assign stat.head_consec = cell_r[HEAD1] == (head + 32'd1);
  assign stat.out_free    = !out_valid_r || !out_stall;
  assign out_valid        = out_valid_r;
  assign out_word         = out_word_r;

endmodule
`default_nettype wire

// ===== hw/rtl/sids_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sids_ctrl: request sequencer for the sorted identifier set
// Issues updates and walks the cell array during a dump, rotating it one entry
// per cycle unless a run word is held up, until the original order is back.
// ----------------------------------------------------------------------------
module sids_ctrl (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  input  wire logic [sids_pkg::OP_W-1:0]         in_op,
  input  sids_pkg::dp_stat_t                     stat,
  output logic                                   in_stall,
  output sids_pkg::dp_cmd_t                      cmd
);

  localparam int CW = sids_pkg::CNT_W;
  localparam int RW = sids_pkg::RUN_W;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_SCAN    = 2'd1;
  localparam logic [1:0] ST_RESTORE = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [RW-1:0] runs_r, runs_nxt;
  logic          start_r, start_nxt;

  logic          accept;
  logic [CW-1:0] k_inc;
  logic          more, cont, run_last;

  assign in_stall = (state_r != ST_IDLE) || !stat.out_free;
  assign accept   = in_valid && !in_stall;
  assign k_inc    = k_r + 1'b1;
  assign more     = k_inc < stat.count;
  assign cont     = more && stat.head_consec;
  assign run_last = !more || (runs_r == RW'(sids_pkg::MAX_RESULTS - 1));

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    runs_nxt  = runs_r;
    start_nxt = start_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if ((in_op == sids_pkg::OP_DUMP) && (stat.count != '0)) begin
            state_nxt = ST_SCAN;
            k_nxt     = '0;
            runs_nxt  = '0;
            start_nxt = 1'b1;
          end else begin
            cmd.apply = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (cont) begin
          // extend the open run
          cmd.rotate     = 1'b1;
          cmd.hold_first = start_r;
          k_nxt          = k_inc;
          start_nxt      = 1'b0;
        end else if (stat.out_free) begin
          cmd.emit_run = 1'b1;
          cmd.use_head = start_r;
          cmd.run_last = run_last;
          cmd.rotate   = 1'b1;
          k_nxt        = k_inc;
          start_nxt    = 1'b1;
          runs_nxt     = runs_r + 1'b1;
          if (run_last) begin
            state_nxt = ST_RESTORE;
          end
        end
      end
      ST_RESTORE: begin
        // finish the full turn so the cells are back in order
        if (k_r == CW'(sids_pkg::CAPACITY)) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.rotate = 1'b1;
          k_nxt      = k_inc;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      runs_r  <= '0;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      runs_r  <= runs_nxt;
      start_r <= start_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sorted_id_set_with_range_dump.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_id_set_with_range_dump: ascending set of 32-bit identifiers
// Insert, delete, query, clear and run dump over a compare-and-shift array.
// ----------------------------------------------------------------------------
// Insert, delete, query, clear and the dump of an empty set each return one
// word; they are accepted back to back while the output register drains. A
// dump of a non-empty set rotates the cell array one entry per cycle unless a
// run word is held up by the output, emitting a word at the end of every run
// of consecutive values, and stalls the input until the full rotation has
// returned the cells to their order.
module sorted_id_set_with_range_dump (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  sids_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  wire logic           out_stall,
  output sids_pkg::out_word_t out_word
);

  sids_pkg::dp_cmd_t  cmd;
  sids_pkg::dp_stat_t stat;

  sids_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_word.op),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  sids_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_word   (in_word),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.apply || cmd.emit_run) |-> (!out_valid || !out_stall))
    else $error("output word overwritten while stalled");

  a_rotate_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rotate |-> (in_stall && !cmd.apply))
    else $error("request taken during dump rotation");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_word.entry_count} <= 7'(sids_pkg::CAPACITY)))
    else $error("entry count above capacity");

  a_run_word_shape: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_run |=> (out_valid && out_word.run_valid && !out_word.was_present))
    else $error("run word malformed");
`endif

endmodule
`default_nettype wire

// ===== tb/sorted_id_set_with_range_dump_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_id_set_with_range_dump_check: result checker for the identifier set
// Watches both channels, keeps its own sorted copy of the set, predicts the
// result words of every accepted request and compares them field by field.
// ----------------------------------------------------------------------------
module sorted_id_set_with_range_dump_check (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_stall,
  input  sids_pkg::in_word_t  in_word,
  input  wire logic           out_valid,
  input  wire logic           out_stall,
  input  sids_pkg::out_word_t out_word,
  output int                  fail_count,
  output int                  pending
);
  import sids_pkg::*;

  logic [ID_W-1:0] set_ids [CAPACITY];
  int              set_count = 0;
  out_word_t       result_words [$];
  out_word_t       want_word;
  int              fails = 0;
  int              waiting = 0;

  assign fail_count = fails;
  assign pending    = waiting;

  function automatic logic [FIELD_CNT_W-1:0] count_now();
    return (set_count > 63) ? 6'd63 : FIELD_CNT_W'(set_count);
  endfunction

  task automatic push_result(input logic present, input logic dropped, input logic valid,
                             input logic [ID_W-1:0] lo, input logic [ID_W-1:0] hi,
                             input logic closes);
    out_word_t w;
    w.was_present  = present;
    w.dropped_full = dropped;
    w.entry_count  = count_now();
    w.run_valid    = valid;
    w.run_first    = lo;
    w.run_final    = hi;
    w.last         = closes;
    result_words.push_back(w);
  endtask

  task automatic predict_request(input in_word_t req);
    int              pos;
    int              idx;
    int              runs;
    int              k;
    logic            present;
    logic [ID_W-1:0] lo;
    logic [ID_W-1:0] hi;
    case (req.op)
      OP_DUMP: begin
        if (set_count == 0) begin
          push_result(1'b0, 1'b0, 1'b0, '0, '0, 1'b1);
        end else begin
          idx  = 0;
          runs = 0;
          while (idx < set_count && runs < MAX_RESULTS) begin
            lo = set_ids[idx];
            hi = lo;
            idx++;
            // extend the run while the next entry is one above its end
            while (idx < set_count && set_ids[idx] == hi + 32'd1) begin
              hi = set_ids[idx];
              idx++;
            end
            push_result(1'b0, 1'b0, 1'b1, lo, hi,
                        (idx >= set_count) || (runs == MAX_RESULTS - 1));
            runs++;
          end
        end
      end
      OP_CLEAR: begin
        set_count = 0;
        push_result(1'b0, 1'b0, 1'b0, '0, '0, 1'b1);
      end
      OP_INSERT, OP_DELETE, OP_QUERY: begin
        pos = 0;
        while (pos < set_count && set_ids[pos] < req.chunk_id) begin
          pos++;
        end
        present = (pos < set_count) && (set_ids[pos] == req.chunk_id);
        if (req.op == OP_INSERT && !present && set_count >= CAPACITY) begin
          push_result(1'b0, 1'b1, 1'b0, '0, '0, 1'b1);
        end else begin
          if (req.op == OP_INSERT && !present) begin
            for (k = set_count; k > pos; k--) begin
              set_ids[k] = set_ids[k-1];
            end
            set_ids[pos] = req.chunk_id;
            set_count++;
          end else if (req.op == OP_DELETE && present) begin
            for (k = pos; k < set_count - 1; k++) begin
              set_ids[k] = set_ids[k+1];
            end
            set_count--;
          end
          push_result(present, 1'b0, 1'b0, '0, '0, 1'b1);
        end
      end
      default: begin
        // unused codes behave as a query that never hits
        push_result(1'b0, 1'b0, 1'b0, '0, '0, 1'b1);
      end
    endcase
  endtask

  function automatic void check_field(input string name, input logic [ID_W-1:0] want,
                                      input logic [ID_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      set_count = 0;
      result_words.delete();
    end else begin
      // take the request first so a same-edge word still finds its expectation
      if (in_valid && !in_stall) begin
        predict_request(in_word);
      end
      if (out_valid && !out_stall) begin
        if (result_words.size() == 0) begin
          $error("result word with no request waiting: %p", out_word);
          fails++;
        end else begin
          want_word = result_words.pop_front();
          check_field("was_present", want_word.was_present, out_word.was_present);
          check_field("dropped_full", want_word.dropped_full, out_word.dropped_full);
          check_field("entry_count", want_word.entry_count, out_word.entry_count);
          check_field("run_valid", want_word.run_valid, out_word.run_valid);
          check_field("run_first", want_word.run_first, out_word.run_first);
          check_field("run_final", want_word.run_final, out_word.run_final);
          check_field("last", want_word.last, out_word.last);
        end
      end
    end
    waiting <= result_words.size();
  end

endmodule

// ===== tb/sorted_id_set_with_range_dump_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_id_set_with_range_dump_test: top of the identifier set testbench
// Drives directed and random request words through the block under several
// idle and stall mixes; the checker beside it predicts and compares results.
// ----------------------------------------------------------------------------
module sorted_id_set_with_range_dump_test;
  import sids_pkg::*;

  localparam int     SETTLE_CYCLES = 40;
  localparam longint LIMIT_NS      = 2_000_000;

  // spare op codes, no operation assigned
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      out_stall = 1'b0;
  in_word_t  in_word   = '0;
  logic      in_stall;
  logic      out_valid;
  out_word_t out_word;
  int        fail_count;
  int        pending;
  int        idle_pct  = 0;
  int        stall_pct = 0;
  int        ep;

  sorted_id_set_with_range_dump uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  sorted_id_set_with_range_dump_check result_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Returns at the edge where the word was taken; valid stays high so the
  // next call can present its word without a gap.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
    in_word_t w;
    w.op       = op;
    w.chunk_id = id;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_word  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold off the sender until every expected word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_phase(input int p);
    case (p)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 58; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 58; end
      default: begin idle_pct = 31; stall_pct = 31; end
    endcase
  endtask

  function automatic logic [ID_W-1:0] random_base();
    case ($urandom_range(0, 3))
      0: return ID_W'($urandom_range(0, 20));
      1: return 32'hFFFF_FFFF - ID_W'($urandom_range(0, 100));
      default: return $urandom;
    endcase
  endfunction

  // Fill the set past capacity in shuffled order, then probe and thin it.
  task automatic fill_episode();
    logic [ID_W-1:0] ids [36];
    logic [ID_W-1:0] tmp;
    int              gap;
    int              a;
    int              b;
    int              k;
    gap    = $urandom_range(0, 2);
    ids[0] = random_base();
    for (k = 1; k < 36; k++) begin
      ids[k] = ids[k-1] + ((gap == 0) ? $urandom_range(1, 2) : gap);
    end
    for (k = 0; k < 24; k++) begin
      a      = $urandom_range(0, 35);
      b      = $urandom_range(0, 35);
      tmp    = ids[a];
      ids[a] = ids[b];
      ids[b] = tmp;
    end
    send_word(OP_CLEAR, $urandom);
    for (k = 0; k < 36; k++) begin
      send_word(OP_INSERT, ids[k]);
      if ($urandom_range(0, 7) == 0) send_word(OP_INSERT, ids[$urandom_range(0, k)]);
      if ($urandom_range(0, 11) == 0) send_word(OP_DUMP, $urandom);
    end
    send_word(OP_DUMP, $urandom);
    send_word(OP_INSERT, ids[$urandom_range(0, 35)]);
    send_word(OP_INSERT, $urandom);
    repeat (4) send_word(OP_QUERY, ($urandom_range(0, 3) == 0) ? $urandom :
                                   ids[$urandom_range(0, 35)]);
    repeat (6) send_word(OP_DELETE, ids[$urandom_range(0, 35)]);
    send_word(OP_DUMP, $urandom);
  endtask

  // Mixed traffic in a narrow window so requests keep hitting held entries.
  task automatic churn_episode();
    logic [ID_W-1:0] base;
    logic [ID_W-1:0] id;
    logic [OP_W-1:0] op;
    int              r;
    int              k;
    base = random_base();
    for (k = 0; k < 20; k++) begin
      r  = $urandom_range(0, 99);
      id = ($urandom_range(0, 9) == 0) ? $urandom : base + $urandom_range(0, 47);
      if (r < 35)      op = OP_INSERT;
      else if (r < 60) op = OP_DELETE;
      else if (r < 78) op = OP_QUERY;
      else if (r < 90) op = OP_DUMP;
      else if (r < 94) op = OP_CLEAR;
      else             op = OP_W'($urandom_range(5, 7));
      send_word(op, id);
    end
  endtask

  task automatic noise_episode();
    logic [ID_W-1:0] base;
    int              k;
    base = random_base();
    for (k = 0; k < 30; k++) begin
      send_word(OP_W'($urandom_range(0, 7)),
                $urandom_range(0, 1) ? $urandom : base + $urandom_range(0, 15));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty set, extremes of the id range, held and missing ids
    send_word(OP_DUMP,   32'h1234_5678);
    send_word(OP_QUERY,  32'h0000_0000);
    send_word(OP_DELETE, 32'hFFFF_FFFF);
    send_word(OP_INSERT, 32'h0000_0000);
    send_word(OP_INSERT, 32'hFFFF_FFFF);
    send_word(OP_INSERT, 32'h0000_0000);
    send_word(OP_QUERY,  32'h0000_0000);
    send_word(OP_QUERY,  32'h0000_0005);
    send_word(OP_QUERY,  32'hFFFF_FFFF);
    send_word(OP_INSERT, 32'h0000_0002);
    send_word(OP_INSERT, 32'h0000_0001);
    send_word(OP_INSERT, 32'hFFFF_FFFE);
    send_word(OP_INSERT, 32'h8000_0000);
    send_word(OP_INSERT, 32'h5555_5555);
    send_word(OP_INSERT, 32'hAAAA_AAAA);
    send_word(OP_DUMP,   32'hFFFF_FFFF);
    send_word(OP_DELETE, 32'h0000_0001);
    send_word(OP_DELETE, 32'h0000_0007);
    send_word(OP_DUMP,   32'h0000_0000);
    send_word(OP_SPARE_A, 32'hFFFF_FFFF);
    send_word(OP_SPARE_B, 32'h0000_0000);
    send_word(OP_SPARE_C, 32'h8000_0000);
    send_word(OP_CLEAR,  32'hDEAD_BEEF);
    send_word(OP_CLEAR,  32'h0000_0000);
    send_word(OP_DUMP,   32'h0F0F_0F0F);

    for (ep = 0; ep < 8; ep++) begin
      drain();
      set_phase(ep % 4);
      case (ep % 3)
        0: fill_episode();
        1: churn_episode();
        default: noise_episode();
      endcase
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("sorted_id_set_with_range_dump_test: PASS");
    end else begin
      $display("sorted_id_set_with_range_dump_test: FAIL");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("sorted_id_set_with_range_dump_test: FAIL");
    $finish;
  end

endmodule
